// File: design/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared widths, command codes, register indexes and reset values for the
// bitmap distinct counter.
// ----------------------------------------------------------------------------
`default_nettype none

package bdc_pkg;

   localparam int VALUE_W    = 64;
   localparam int COUNT_W    = 17;
   localparam int SIZE_REG_W = 17;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Bitmap memory word.
   localparam int WORD_BITS = 64;
   localparam int BITPOS_W  = 6;

   // Remainder unit: bits of the offset consumed per cycle.
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = VALUE_W / DIV_BITS;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_COL_MIN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_MAX    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_SIZE = 2'd2;

   localparam logic [VALUE_W-1:0]    COL_MIN_RESET    = 64'd0;
   localparam logic [VALUE_W-1:0]    COL_MAX_RESET    = 64'd65535;
   localparam logic [SIZE_REG_W-1:0] RANGE_SIZE_RESET = 17'd65536;

endpackage : bdc_pkg

`default_nettype wire

// File: design/bitmap_distinct_counter_core.sv
// Insert and query of an in-range value: the result strobe follows 16 remainder steps of
// 4 offset bits, one bitmap read and one update, with busy high until then. Out-of-range
// values: result the cycle after start, one beat per cycle while idle. Report: result the
// cycle after start, then busy while the bitmap memory is swept. After reset the same sweep
// runs over all WORD_COUNT words (1024 at the default size) with busy high;
// configuration writes are taken at any time. Results cannot be stalled.
// ----------------------------------------------------------------------------
// bitmap_distinct_counter_core
// Counts distinct column values in a bitmap held in a word-wide memory,
// mapping each value to a bit by its offset from the column minimum modulo
// the configured bitmap size.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_distinct_counter_core #(
   parameter int BITMAP_BITS = 65536
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [bdc_pkg::CMD_W-1:0]           req_cmd,
   input  wire logic [bdc_pkg::VALUE_W-1:0]         req_value,
   output logic                                     rsp_strobe,
   output logic                                     rsp_present,
   output logic      [bdc_pkg::COUNT_W-1:0]         rsp_unique_total,
   output logic                                     rsp_out_of_range,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [bdc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [bdc_pkg::VALUE_W-1:0]         csr_wdata
);

   import bdc_pkg::*;

   localparam int SIZE_W     = $clog2(BITMAP_BITS + 1);
   localparam int WORD_COUNT = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam logic [31:0]        BITMAP_BITS_W = 32'(BITMAP_BITS);
   localparam logic [WADDR_W-1:0] LAST_WORD     = WADDR_W'(WORD_COUNT - 1);
   localparam logic [STEP_W-1:0]  LAST_STEP     = STEP_W'(DIV_STEPS - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIVIDE = 5'b00010,
      ST_LOOKUP = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_CLEAR  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [VALUE_W-1:0]    col_min_ff, col_max_ff;
   logic [SIZE_REG_W-1:0] range_size_ff;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [VALUE_W-1:0]    offs_ff, offs_in;
   logic [SIZE_W-1:0]     rem_ff, rem_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [WADDR_W-1:0]    clr_addr_ff, clr_addr_in;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic                  rsp_present_ff, rsp_present_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                  rsp_oor_ff, rsp_oor_in;

   logic                  accept;
   logic                  req_oor;
   logic [31:0]           size_wide;
   logic [SIZE_W-1:0]     size_now;
   logic [SIZE_W-1:0]     rem_step;
   logic [SIZE_W:0]       trial;
   logic [31:0]           idx_wide;
   logic [WADDR_W-1:0]    word_addr;
   logic [BITPOS_W-1:0]   bit_pos;
   logic                  bit_set;

   logic                  ram_wr_en, ram_rd_en;
   logic [WADDR_W-1:0]    ram_wr_addr;
   logic [WORD_BITS-1:0]  ram_wr_data, ram_rd_data;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign req_oor = (req_value < col_min_ff) || (req_value > col_max_ff);

   // A size of zero or beyond the bitmap falls back to the full bitmap.
   assign size_wide = ((range_size_ff == '0) || (32'(range_size_ff) > BITMAP_BITS_W))
                      ? BITMAP_BITS_W : 32'(range_size_ff);
   assign size_now  = size_wide[SIZE_W-1:0];

   // Restoring remainder, DIV_BITS offset bits per cycle, most significant first.
   // An in-range offset below the span already lies below the size whenever
   // the size equals the span, so the remainder covers both mapping cases.
   always_comb begin
      rem_step = rem_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial = {rem_step, offs_ff[VALUE_W-1-k]};
         if (trial >= {1'b0, size_ff}) begin
            trial = trial - {1'b0, size_ff};
         end
         rem_step = trial[SIZE_W-1:0];
      end
   end

   assign idx_wide  = 32'(rem_ff);
   assign word_addr = idx_wide[WADDR_W+BITPOS_W-1:BITPOS_W];
   assign bit_pos   = idx_wide[BITPOS_W-1:0];
   assign bit_set   = ram_rd_data[bit_pos];

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      cmd_in         = cmd_ff;
      offs_in        = offs_ff;
      rem_in         = rem_ff;
      size_in        = size_ff;
      step_in        = step_ff;
      clr_addr_in    = clr_addr_ff;
      rsp_strobe_in  = 1'b0;
      rsp_present_in = rsp_present_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_oor_in     = rsp_oor_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = word_addr;
      ram_wr_data    = ram_rd_data | (WORD_BITS'(1) << bit_pos);
      ram_rd_en      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_INSERT, CMD_QUERY: begin
                     if (req_oor) begin
                        rsp_strobe_in  = 1'b1;
                        rsp_present_in = 1'b0;
                        rsp_count_in   = count_ff;
                        rsp_oor_in     = 1'b1;
                     end else begin
                        cmd_in   = req_cmd;
                        offs_in  = req_value - col_min_ff;
                        rem_in   = '0;
                        size_in  = size_now;
                        step_in  = '0;
                        state_in = ST_DIVIDE;
                     end
                  end
                  CMD_REPORT: begin
                     rsp_strobe_in  = 1'b1;
                     rsp_present_in = 1'b0;
                     rsp_count_in   = count_ff;
                     rsp_oor_in     = 1'b0;
                     count_in       = '0;
                     clr_addr_in    = '0;
                     state_in       = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            rem_in  = rem_step;
            offs_in = offs_ff << DIV_BITS;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            ram_rd_en = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            if ((cmd_ff == CMD_INSERT) && !bit_set) begin
               ram_wr_en = 1'b1;
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            rsp_strobe_in  = 1'b1;
            rsp_present_in = bit_set;
            rsp_count_in   = count_in;
            rsp_oor_in     = 1'b0;
            state_in       = ST_IDLE;
         end
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + WADDR_W'(1);
            if (clr_addr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         col_min_ff    <= COL_MIN_RESET;
         col_max_ff    <= COL_MAX_RESET;
         range_size_ff <= RANGE_SIZE_RESET;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COL_MIN:    col_min_ff    <= csr_wdata;
               CSR_COL_MAX:    col_max_ff    <= csr_wdata;
               CSR_RANGE_SIZE: range_size_ff <= csr_wdata[SIZE_REG_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      offs_ff        <= offs_in;
      rem_ff         <= rem_in;
      size_ff        <= size_in;
      step_ff        <= step_in;
      rsp_present_ff <= rsp_present_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_oor_ff     <= rsp_oor_in;
   end

   bdc_ram #(
      .WIDTH  (WORD_BITS),
      .DEPTH  (WORD_COUNT),
      .ADDR_W (WADDR_W)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (word_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_present      = rsp_present_ff;
   assign rsp_unique_total = rsp_count_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule : bitmap_distinct_counter_core

`default_nettype wire

// File: design/bdc_ram.sv
// ----------------------------------------------------------------------------
// bdc_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : bdc_ram

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives insert, query, report and unused command beats into the bitmap
// distinct counter under a series of column ranges and bitmap sizes, and
// checks every result beat against a bit-accurate bitmap predictor.
// ----------------------------------------------------------------------------

module tb;

   import bdc_pkg::*;

   localparam int BITMAP_BITS = 65536;
   localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
   } bitmap_cmd_type;

   typedef struct packed {
      logic               present;
      logic [COUNT_W-1:0] unique_total;
      logic               out_of_range;
   } bitmap_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [CMD_W-1:0]     req_cmd = CMD_INSERT;
   logic [VALUE_W-1:0]   req_value = '0;
   logic                 rsp_strobe;
   logic                 rsp_present;
   logic [COUNT_W-1:0]   rsp_unique_total;
   logic                 rsp_out_of_range;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_COL_MIN;
   logic [VALUE_W-1:0]   csr_wdata = '0;

   // Predictor state: configuration copy, bitmap and running count.
   logic [VALUE_W-1:0]     lo_bound = COL_MIN_RESET;
   logic [VALUE_W-1:0]     hi_bound = COL_MAX_RESET;
   logic [SIZE_REG_W-1:0]  size_reg = RANGE_SIZE_RESET;
   logic [BITMAP_BITS-1:0] seen_map = '0;
   logic [COUNT_W-1:0]     seen_total = '0;

   bitmap_cmd_type    cmd_backlog[$];
   bitmap_result_type awaited_results[$];

   logic beat_taken = 1'b0;
   logic steady = 1'b0;
   int   hold_off = 0;
   int   mismatches = 0;
   int   n_insert = 0, n_query = 0, n_report = 0, n_unused = 0;
   int   n_checked = 0, n_hits = 0, n_oor = 0, n_settings = 1;

   bitmap_distinct_counter_core #(
      .BITMAP_BITS(BITMAP_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_present(rsp_present),
      .rsp_unique_total(rsp_unique_total),
      .rsp_out_of_range(rsp_out_of_range),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [VALUE_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Size register write data with random bits above the register width.
   function automatic logic [VALUE_W-1:0] size_word(input logic [SIZE_REG_W-1:0] size);
      return {$urandom, 15'($urandom), size};
   endfunction

   function automatic bitmap_result_type predict_bitmap_op(input logic [CMD_W-1:0] op,
                                                           input logic [VALUE_W-1:0] val);
      bitmap_result_type res;
      logic [VALUE_W-1:0] eff_size, offs, span, slot;
      int unsigned pos;
      res = '0;
      if (op == CMD_REPORT) begin
         res.unique_total = seen_total;
         seen_map = '0;
         seen_total = '0;
      end else begin
         res.out_of_range = (val < lo_bound) || (val > hi_bound);
         if (!res.out_of_range) begin
            eff_size = (size_reg == '0 || size_reg > BITMAP_BITS) ?
                       64'(BITMAP_BITS) : 64'(size_reg);
            offs = val - lo_bound;
            // The span wraps to zero when the range covers all 64-bit values.
            span = hi_bound - lo_bound + 64'd1;
            slot = (eff_size == span) ? offs : offs % eff_size;
            pos  = int'(slot % BITMAP_BITS);
            res.present = seen_map[pos];
            if (op == CMD_INSERT && !res.present) begin
               seen_map[pos] = 1'b1;
               if (seen_total != COUNT_MAX)
                  seen_total++;
            end
         end
         res.unique_total = seen_total;
      end
      return res;
   endfunction

   // Driver: command beats change on the falling edge.
   always @(negedge clock) begin : driver
      bitmap_cmd_type item;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (start) begin
            if ($urandom_range(0, 39) == 0)
               steady = !steady;
            hold_off = steady ? 0 : $urandom_range(0, 4);
         end
         if (hold_off == 0 && cmd_backlog.size() != 0) begin
            item = cmd_backlog.pop_front();
            start     <= 1'b1;
            req_cmd   <= item.cmd;
            req_value <= item.value;
         end else begin
            if (hold_off > 0)
               hold_off--;
            start     <= 1'b0;
            req_cmd   <= CMD_W'($urandom);
            req_value <= rand64();
         end
      end
   end

   // Monitor: tracks accepted beats and register writes, checks result beats.
   always @(posedge clock) begin : monitor
      bitmap_result_type want, got;
      beat_taken <= start && !busy;
      if (reset) begin
         lo_bound   = COL_MIN_RESET;
         hi_bound   = COL_MAX_RESET;
         size_reg   = RANGE_SIZE_RESET;
         seen_map   = '0;
         seen_total = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COL_MIN:    lo_bound = csr_wdata;
               CSR_COL_MAX:    hi_bound = csr_wdata;
               CSR_RANGE_SIZE: size_reg = csr_wdata[SIZE_REG_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            case (req_cmd)
               CMD_INSERT: n_insert++;
               CMD_QUERY:  n_query++;
               CMD_REPORT: n_report++;
               default:    n_unused++;
            endcase
            if (req_cmd != CMD_UNUSED)
               awaited_results.push_back(predict_bitmap_op(req_cmd, req_value));
         end
         if (rsp_strobe !== 1'b0) begin
            got = {rsp_present, rsp_unique_total, rsp_out_of_range};
            if (awaited_results.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result beat: present %b count %0d out_of_range %b",
                           got.present, got.unique_total, got.out_of_range);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               if (got.present !== want.present ||
                   got.unique_total !== want.unique_total ||
                   got.out_of_range !== want.out_of_range) begin
                  if (mismatches < 10)
                     $display("mismatch: present %b/%b count %0d/%0d oor %b/%b (exp/act)",
                              want.present, got.present, want.unique_total,
                              got.unique_total, want.out_of_range, got.out_of_range);
                  mismatches++;
               end
               n_checked++;
               if (got.present === 1'b1)
                  n_hits++;
               if (got.out_of_range === 1'b1)
                  n_oor++;
            end
         end
      end
   end

   // Waits until every beat went in and every result came back, then lets
   // unused commands and the clearing sweep run out.
   task automatic settle();
      @(negedge clock);
      while (cmd_backlog.size() != 0 || start || awaited_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      while (busy !== 1'b0)
         @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_index <= CSR_IDX_W'($urandom);
      csr_wdata <= rand64();
   endtask

   task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] val);
      cmd_backlog.push_back('{op, val});
   endtask

   task automatic run_phase(input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi,
                            input logic [VALUE_W-1:0] size_data, input int unsigned spread,
                            input int count);
      logic [VALUE_W-1:0] v, span;
      logic [CMD_W-1:0]   op;
      int unsigned        pick;
      settle();
      write_csr(CSR_COL_MIN, lo);
      write_csr(CSR_COL_MAX, hi);
      write_csr(CSR_RANGE_SIZE, size_data);
      n_settings++;
      span = hi - lo + 64'd1;
      @(posedge clock);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 57)      op = CMD_INSERT;
         else if (pick < 94) op = CMD_QUERY;
         else if (pick < 97) op = CMD_REPORT;
         else                op = CMD_UNUSED;
         case ($urandom_range(0, 9))
            7: v = (span == '0) ? rand64() : lo + rand64() % span;
            8: v = rand64();
            9: begin
               case ($urandom_range(0, 5))
                  0: v = lo;
                  1: v = hi;
                  2: v = lo - 64'd1;
                  3: v = hi + 64'd1;
                  4: v = '0;
                  default: v = '1;
               endcase
            end
            default: v = lo + 64'($urandom_range(0, spread));
         endcase
         push_cmd(op, v);
      end
      push_cmd(CMD_REPORT, rand64());
   endtask

   initial begin : timeout
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [VALUE_W-1:0] base;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats under the reset register values.
      push_cmd(CMD_INSERT, 64'd0);
      push_cmd(CMD_INSERT, 64'd0);
      push_cmd(CMD_QUERY,  64'd0);
      push_cmd(CMD_QUERY,  64'd65535);
      push_cmd(CMD_INSERT, 64'd65535);
      push_cmd(CMD_QUERY,  64'd65535);
      push_cmd(CMD_INSERT, 64'd65536);
      push_cmd(CMD_QUERY,  64'd65536);
      push_cmd(CMD_INSERT, '1);
      push_cmd(CMD_QUERY,  '1);
      push_cmd(CMD_INSERT, 64'd12345);
      push_cmd(CMD_UNUSED, 64'd12345);
      push_cmd(CMD_QUERY,  64'd12345);
      push_cmd(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
      push_cmd(CMD_REPORT, 64'h5555_5555_5555_5555);
      push_cmd(CMD_QUERY,  64'd0);
      push_cmd(CMD_REPORT, '0);
      push_cmd(CMD_UNUSED, '1);
      push_cmd(CMD_INSERT, 64'd40000);
      push_cmd(CMD_REPORT, '1);

      // Full 64-bit range: the span wraps, so indexing goes through the modulo.
      run_phase('0, '1, size_word(17'd65536), 200, 160);
      // Narrow range at the top of the value space, direct indexing.
      run_phase('1 - 64'd99, '1, size_word(17'd100), 150, 150);
      // Minimum above maximum: every value is out of range.
      run_phase(64'd1000, 64'd500, size_word(17'd17), 2000, 60);
      base = rand64();
      // A size of zero falls back to the full bitmap.
      run_phase(base, base + 64'd4095, size_word(17'd0), 5000, 150);
      base = rand64();
      // A size above the bitmap capacity also falls back to the full bitmap.
      run_phase(base, base + 64'd200000, size_word(17'h1FFFF), 150000, 150);
      run_phase(64'd7, 64'd9999, size_word(17'd1), 50, 100);
      run_phase(64'd5, 64'd5000, size_word(17'd37), 300, 150);
      for (int r = 0; r < 2; r++) begin
         base = rand64();
         run_phase(base, ($urandom_range(0, 1) == 0) ? base + 64'($urandom_range(0, 100000))
                                                    : rand64(),
                   size_word(17'($urandom_range(1, 65536))), 3000, 150);
      end
      settle();
      write_csr(CSR_UNUSED, rand64());
      run_phase(64'd0, 64'd65534, size_word(17'd65535), 400, 150);
      run_phase('1, '1, size_word(17'd1), 3, 50);

      settle();
      $display("covered %0d inserts, %0d queries, %0d reports, %0d unused over %0d settings",
               n_insert, n_query, n_report, n_unused, n_settings);
      $display("checked %0d result beats: %0d with the bit set, %0d out of range",
               n_checked, n_hits, n_oor);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, awaited_results.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: bitmap_distinct_counter_core.f
design/bdc_pkg.sv
design/bdc_ram.sv
design/bitmap_distinct_counter_core.sv
test/tb.sv
